>>> rtl/pfsc_pkg.sv
package pfsc_pkg;

    localparam logic [2:0] FMT_FLOAT32 = 3'd0;
    localparam logic [2:0] FMT_INT32   = 3'd1;
    localparam logic [2:0] FMT_INT24   = 3'd2;
    localparam logic [2:0] FMT_INT16   = 3'd3;

    localparam logic KIND_CAPTURE  = 1'b0;
    localparam logic KIND_PLAYBACK = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] sample_in;
        logic        last_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0] sample_out;
        logic        not_converted;
        logic        last_out;
    } out_item_t;

endpackage

>>> rtl/pcm_float_sample_converter.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | pfsc_pkg::in_item_t
// out     | output    | out_valid/out_stall| pfsc_pkg::out_item_t
// cfg     | input     | cfg_valid/cfg_ready| 3-bit sample format
//
// One sample per cycle unless stalled; results register on transfer.
// The conversion is a single combinational pass into the result register.
// rst_n clears the format to float32 and empties the result register.
// A stalled result holds the register and stalls the input side.
module pcm_float_sample_converter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pfsc_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pfsc_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_data
);
    import pfsc_pkg::*;

    logic [2:0]  fmt_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    out_item_t   out_data_next;
    logic        in_take;

    // capture path
    logic [31:0] cap_mag;
    logic        cap_neg;
    logic [7:0]  cap_shift;
    logic [4:0]  cap_pos;
    logic [31:0] cap_norm;
    logic [24:0] cap_m;
    logic        cap_rnd;
    logic [7:0]  cap_exp;
    logic [31:0] cap_res;

    // playback path
    logic        pb_sign;
    logic [7:0]  pb_e;
    logic [22:0] pb_frac;
    logic [23:0] pb_sig;
    logic        pb_nan;
    logic [30:0] pb_wide;
    logic [30:0] pb_mag32;
    logic [31:0] pb_i32;
    logic [38:0] pb_prod;
    logic [38:0] pb_pn;
    logic [14:0] pb_rem;
    logic [24:0] pb_m;
    logic        pb_rnd;
    logic signed [9:0] pb_s;
    logic [31:0] pb_mag16;
    logic [15:0] pb_i16;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        cap_mag   = 32'd0;
        cap_neg   = 1'b0;
        cap_shift = 8'd31;
        case (fmt_reg)
            FMT_INT32:
            begin
                cap_neg   = in_data.sample_in[31];
                cap_mag   = cap_neg ? (32'd0 - in_data.sample_in) : in_data.sample_in;
                cap_shift = 8'd31;
            end
            FMT_INT24:
            begin
                cap_neg   = in_data.sample_in[23];
                cap_mag   = {8'd0, cap_neg ? (24'd0 - in_data.sample_in[23:0])
                                           : in_data.sample_in[23:0]};
                if (cap_neg && in_data.sample_in[23:0] == 24'h800000)
                    cap_mag = 32'h00800000;
                cap_shift = 8'd23;
            end
            FMT_INT16:
            begin
                cap_neg   = in_data.sample_in[15];
                cap_mag   = {16'd0, cap_neg ? (16'd0 - in_data.sample_in[15:0])
                                           : in_data.sample_in[15:0]};
                if (cap_neg && in_data.sample_in[15:0] == 16'h8000)
                    cap_mag = 32'h00008000;
                cap_shift = 8'd15;
            end
            default:
            begin
                cap_mag = 32'd0;
            end
        endcase

        cap_pos = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (cap_mag[i])
                cap_pos = 5'(i);
        end
        cap_norm = cap_mag << (5'd31 - cap_pos);
        cap_rnd  = (cap_norm[7:0] > 8'h80) || (cap_norm[7:0] == 8'h80 && cap_norm[8]);
        cap_m    = {1'b0, cap_norm[31:8]} + {24'd0, cap_rnd};
        cap_exp  = 8'({3'd0, cap_pos} + 8'd127 - cap_shift + {7'd0, cap_m[24]});
        if (cap_mag == 32'd0)
            cap_res = 32'd0;
        else if (cap_m[24])
            cap_res = {cap_neg, cap_exp, 23'd0};
        else
            cap_res = {cap_neg, cap_exp, cap_m[22:0]};
        if (fmt_reg == FMT_FLOAT32)
            cap_res = in_data.sample_in;
    end

    always_comb
    begin
        pb_sign = in_data.sample_in[31];
        pb_e    = in_data.sample_in[30:23];
        pb_frac = in_data.sample_in[22:0];
        pb_sig  = {pb_e != 8'd0, pb_frac};
        pb_nan  = (pb_e == 8'hFF) && (pb_frac != 23'd0);

        // int32: f * 2^31 truncated
        pb_wide = {pb_sig, 7'd0};
        if (pb_e >= 8'd95 && pb_e <= 8'd126)
            pb_mag32 = pb_wide >> (8'd126 - pb_e);
        else
            pb_mag32 = 31'd0;
        if (pb_nan)
            pb_i32 = 32'd0;
        else if (pb_e >= 8'd127)
            pb_i32 = pb_sign ? 32'h80000000 : 32'h7FFFFFFF;
        else
            pb_i32 = pb_sign ? (32'd0 - {1'b0, pb_mag32}) : {1'b0, pb_mag32};

        // int16: f * 32767 rounded to 24 significant bits, then truncated
        pb_prod = 39'(pb_sig) * 39'd32767;
        pb_pn   = pb_prod[38] ? pb_prod : (pb_prod << 1);
        pb_rem  = pb_pn[14:0];
        pb_rnd  = (pb_rem > 15'h4000) || (pb_rem == 15'h4000 && pb_pn[15]);
        pb_m    = {1'b0, pb_pn[38:15]} + {24'd0, pb_rnd};
        pb_s    = $signed({2'b00, pb_e}) - 10'sd150 + (pb_prod[38] ? 10'sd15 : 10'sd14);
        if (pb_s >= 10'sd0)
            pb_mag16 = {7'd0, pb_m} << pb_s[2:0];
        else if (pb_s < -10'sd25)
            pb_mag16 = 32'd0;
        else
            pb_mag16 = {7'd0, pb_m >> 5'(-pb_s)};
        if (pb_nan || pb_e == 8'd0)
            pb_i16 = 16'd0;
        else if (pb_e >= 8'd142 || pb_mag16 >= 32'd32768)
            pb_i16 = pb_sign ? 16'h8000 : 16'h7FFF;
        else
            pb_i16 = pb_sign ? (16'd0 - pb_mag16[15:0]) : pb_mag16[15:0];
    end

    always_comb
    begin
        out_data_next.last_out      = in_data.last_in;
        out_data_next.not_converted = 1'b0;
        out_data_next.sample_out    = cap_res;
        if (in_data.kind == KIND_PLAYBACK)
        begin
            case (fmt_reg)
                FMT_FLOAT32: out_data_next.sample_out = in_data.sample_in;
                FMT_INT32:   out_data_next.sample_out = pb_i32;
                FMT_INT24:   out_data_next.sample_out = {8'd0, pb_i32[31:8]};
                FMT_INT16:   out_data_next.sample_out = {16'd0, pb_i16};
                default:
                begin
                    out_data_next.sample_out    = 32'd0;
                    out_data_next.not_converted = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_FLOAT32;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                fmt_reg <= cfg_data;
            if (!in_stall)
                out_valid_reg <= in_valid;
        end
    end

    // advance result on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_take)
            out_data_reg <= out_data_next;
    end

endmodule
